// ===== src/lad_pkg.sv =====
// Shared types and constants for the line-average deinterlacer.
package lad_pkg;

    // Default upper bound on the line store depth
    localparam int MAX_WIDTH_DEFAULT = 4096;

    // Register file layout
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 13;
    localparam logic [CFG_INDEX_W-1:0] REG_LINE_WIDTH   = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_FRAME_HEIGHT = 2'd1;

    // Register reset values
    localparam logic [CFG_DATA_W-1:0] LINE_WIDTH_RESET   = 13'd720;
    localparam logic [CFG_DATA_W-1:0] FRAME_HEIGHT_RESET = 13'd480;

    // Largest frame height the row counter covers
    localparam logic [CFG_DATA_W-1:0] HEIGHT_CAP = 13'd4096;

    // Coordinate and pixel widths
    localparam int COORD_W = 12;
    localparam int PIXEL_W = 8;

    // Result sequencer: which beat of the current even-row pixel goes out next
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_AVG,
        ST_PASS,
        ST_COPY
    } emit_state_t;

endpackage

// ===== src/line_average_deinterlacer_top.sv =====
// Line-averaging bob deinterlacer: line store, raster counters and result sequencer.
//
// Pixels arrive one per beat in raster order on s_t*. Even rows pass through;
// each odd row is rebuilt as the rounded average of the even rows around it,
// emitted just ahead of the even pixel below it; when the height is even the
// last odd row is a copy of the row above it. Odd-row input pixels produce no
// result. An even-row pixel yields one to three result beats on m_t*, one per
// cycle unless m_tready stalls, with m_tlast on the final one; the result
// sequencer drives them into the output register and takes the next pixel as
// the last beat is loaded. The line store is a single-port memory of
// MAX_WIDTH bytes, read and written in the same accept cycle (old value out,
// new pixel in), so no clearing pass is needed; entries beyond a width that grew
// mid-frame read back as whatever they last held. Configuration (cfg_*) is
// always ready and should only be written while the block is idle.
module line_average_deinterlacer_top #(
    parameter int MAX_WIDTH = lad_pkg::MAX_WIDTH_DEFAULT
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    // Configuration write channel
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [lad_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [lad_pkg::CFG_DATA_W-1:0]  cfg_data,
    // Pixel input
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [7:0]                     s_tdata,   // [7:0] pixel
    // Result output
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [31:0]                    m_tdata,   // [11:0] out_row, [23:12] out_col,
                                                      // [31:24] value
    output logic                           m_tlast    // last
);

    localparam int ADDR_W = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int WCAP   = (MAX_WIDTH < 4096) ? MAX_WIDTH : 4096;
    localparam int CW     = lad_pkg::COORD_W;
    localparam int DW     = lad_pkg::CFG_DATA_W;
    localparam int PW     = lad_pkg::PIXEL_W;

    // Configuration registers
    logic [DW-1:0] line_width_reg;
    logic [DW-1:0] frame_height_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            line_width_reg   <= lad_pkg::LINE_WIDTH_RESET;
            frame_height_reg <= lad_pkg::FRAME_HEIGHT_RESET;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                lad_pkg::REG_LINE_WIDTH:   line_width_reg   <= cfg_data;
                lad_pkg::REG_FRAME_HEIGHT: frame_height_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // Effective bounds: zero acts as one, large values are capped
    logic [DW-1:0] w_eff;
    logic [DW-1:0] h_eff;

    always_comb begin
        if (line_width_reg == '0)
            w_eff = DW'(1);
        else if (line_width_reg > DW'(WCAP))
            w_eff = DW'(WCAP);
        else
            w_eff = line_width_reg;

        if (frame_height_reg == '0)
            h_eff = DW'(1);
        else if (frame_height_reg > lad_pkg::HEIGHT_CAP)
            h_eff = lad_pkg::HEIGHT_CAP;
        else
            h_eff = frame_height_reg;
    end

    // Raster counters
    logic [CW-1:0] col_cnt_reg, col_cnt_next;
    logic [CW-1:0] row_cnt_reg, row_cnt_next;
    logic [CW-1:0] c_cur, r_cur;
    logic [DW-1:0] row_tmp, col_plus, row_plus;
    logic          cur_even, cur_has_avg, cur_has_copy;

    always_comb begin
        // wrap a counter that sits at or past a bound lowered mid-frame
        if ({1'b0, col_cnt_reg} >= w_eff) begin
            c_cur   = '0;
            row_tmp = {1'b0, row_cnt_reg} + DW'(1);
        end else begin
            c_cur   = col_cnt_reg;
            row_tmp = {1'b0, row_cnt_reg};
        end
        r_cur = (row_tmp >= h_eff) ? '0 : row_tmp[CW-1:0];

        // advance past this pixel
        col_plus = {1'b0, c_cur} + DW'(1);
        row_plus = {1'b0, r_cur} + DW'(1);
        if (col_plus >= w_eff) begin
            col_cnt_next = '0;
            row_cnt_next = (row_plus >= h_eff) ? '0 : row_plus[CW-1:0];
        end else begin
            col_cnt_next = col_plus[CW-1:0];
            row_cnt_next = r_cur;
        end

        cur_even     = ~r_cur[0];
        cur_has_avg  = (r_cur[CW-1:1] != '0);
        cur_has_copy = ~h_eff[0] && (({1'b0, r_cur} + DW'(2)) == h_eff);
    end

    // Handshake control
    lad_pkg::emit_state_t state_reg, state_next;
    logic out_load;
    logic beat_last;
    logic s_fire;
    logic acc_even;

    assign out_load = !m_tvalid || m_tready;
    assign s_tready = (state_reg == lad_pkg::ST_IDLE) || (out_load && beat_last);
    assign s_fire   = s_tvalid && s_tready;
    assign acc_even = s_fire && cur_even;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_cnt_reg <= '0;
            row_cnt_reg <= '0;
        end else if (s_fire) begin
            col_cnt_reg <= col_cnt_next;
            row_cnt_reg <= row_cnt_next;
        end
    end

    // Line store: old entry read out and new pixel written in one access
    logic [PW-1:0]     line_mem [MAX_WIDTH];
    logic [PW-1:0]     old_s_reg;
    logic [ADDR_W-1:0] mem_addr;

    assign mem_addr = ADDR_W'(c_cur);

    always_ff @(posedge aclk) begin
        if (acc_even) begin
            old_s_reg          <= line_mem[mem_addr];
            line_mem[mem_addr] <= s_tdata;
        end
    end

    // Held item for the sequencer
    logic [CW-1:0] row_s_reg, col_s_reg;
    logic [PW-1:0] px_s_reg;
    logic          copy_s_reg;

    always_ff @(posedge aclk) begin
        if (acc_even) begin
            row_s_reg  <= r_cur;
            col_s_reg  <= c_cur;
            px_s_reg   <= s_tdata;
            copy_s_reg <= cur_has_copy;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn)
            state_reg <= lad_pkg::ST_IDLE;
        else
            state_reg <= state_next;
    end

    // Sequencer next state
    always_comb begin
        state_next = state_reg;
        if (out_load) begin
            unique case (state_reg)
                lad_pkg::ST_IDLE: state_next = lad_pkg::ST_IDLE;
                lad_pkg::ST_AVG:  state_next = lad_pkg::ST_PASS;
                lad_pkg::ST_PASS: state_next = copy_s_reg ? lad_pkg::ST_COPY
                                                          : lad_pkg::ST_IDLE;
                lad_pkg::ST_COPY: state_next = lad_pkg::ST_IDLE;
                default:          state_next = lad_pkg::ST_IDLE;
            endcase
        end
        if (acc_even)
            state_next = cur_has_avg ? lad_pkg::ST_AVG : lad_pkg::ST_PASS;
    end

    // Sequencer outputs: the beat for the current state
    logic [PW:0]   avg_sum;
    logic [CW-1:0] beat_row;
    logic [PW-1:0] beat_value;
    logic          beat_valid;

    assign avg_sum = {1'b0, old_s_reg} + {1'b0, px_s_reg} + (PW+1)'(1);

    always_comb begin
        beat_valid = 1'b1;
        beat_row   = row_s_reg;
        beat_value = px_s_reg;
        beat_last  = 1'b0;
        unique case (state_reg)
            lad_pkg::ST_IDLE: begin
                beat_valid = 1'b0;
            end
            lad_pkg::ST_AVG: begin
                beat_row   = row_s_reg - CW'(1);
                beat_value = avg_sum[PW:1];
            end
            lad_pkg::ST_PASS: begin
                beat_last = ~copy_s_reg;
            end
            lad_pkg::ST_COPY: begin
                beat_row  = row_s_reg + CW'(1);
                beat_last = 1'b1;
            end
            default: beat_valid = 1'b0;
        endcase
    end

    // Output register
    logic        m_tvalid_reg;
    logic [31:0] m_tdata_reg;
    logic        m_tlast_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn)
            m_tvalid_reg <= 1'b0;
        else if (out_load)
            m_tvalid_reg <= beat_valid;
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            m_tdata_reg <= {beat_value, col_s_reg, beat_row};
            m_tlast_reg <= beat_last;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tlast  = m_tlast_reg;

    // Checks
    a_avg_needs_row_above: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == lad_pkg::ST_AVG |-> row_s_reg[CW-1:1] != '0)
        else $error("average beat for a row without an even row above");

    a_copy_only_when_flagged: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == lad_pkg::ST_COPY |-> copy_s_reg)
        else $error("copy beat without a last-line copy pending");

    a_even_pixel_starts_sequence: assert property (@(posedge aclk) disable iff (!aresetn)
        $past(aresetn) && $past(acc_even) |-> state_reg != lad_pkg::ST_IDLE)
        else $error("even-row pixel accepted but no beats scheduled");

    a_odd_row_held_dropped: assert property (@(posedge aclk) disable iff (!aresetn)
        $past(aresetn) && $past(s_fire) && !$past(cur_even) && $past(beat_last)
        |-> state_reg == lad_pkg::ST_IDLE)
        else $error("odd-row pixel started a result sequence");

endmodule
